// ===== design/s2c_pkg.sv =====
// Shared types, constants and the control store for the seconds-to-calendar converter.
// Used by seconds_to_calendar; depends on nothing else.
`default_nettype none

package s2c_pkg;

  // Widths of the converter's fields and internal values.
  localparam int unsigned SecW   = 32;   // input second count
  localparam int unsigned RemW   = 17;   // seconds into the day, below 86400
  localparam int unsigned DaysW  = 16;   // whole days, at most 49710
  localparam int unsigned YearW  = 12;
  localparam int unsigned PcW    = 4;
  localparam int unsigned OutW   = 48;   // packed result, 41 bits used

  localparam logic [YearW-1:0] BASE_YEAR   = 12'd2000;
  localparam logic [DaysW-1:0] WEEK_OFFSET = 16'd5;    // 2000-01-01 was a Saturday
  localparam logic [8:0]       YEAR_DAYS   = 9'd365;
  localparam logic [8:0]       LEAP_DAYS   = 9'd366;

  localparam logic [RemW-1:0] DIV_DAY  = 17'd86400;
  localparam logic [RemW-1:0] DIV_HOUR = 17'd3600;
  localparam logic [RemW-1:0] DIV_MIN  = 17'd60;
  localparam logic [RemW-1:0] DIV_WEEK = 17'd7;

  // Rounded-up reciprocals for exact quotients by multiply and shift.
  // Seconds / 86400 is (seconds >> 7) / 675, taken as a product shifted right by 35.
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // 2^35 / 675, rounded up
  // Seconds into the day / 3600 is (value >> 4) / 225, shifted right by 21.
  localparam logic [13:0] RECIP_HOUR = 14'd9321;      // 2^21 / 225, rounded up
  // Seconds into the hour / 60 is (value >> 2) / 15, shifted right by 14.
  localparam logic [10:0] RECIP_MIN  = 11'd1093;      // 2^14 / 15, rounded up
  // Day number / 7, shifted right by 19.
  localparam logic [16:0] RECIP_WEEK = 17'd74899;     // 2^19 / 7, rounded up

  // Datapath operation of one control word.
  typedef enum logic [2:0] {
    OP_DIV,        // quotient by reciprocal multiplication
    OP_SAVE_DAYS,  // keep day count and the seconds into the day
    OP_SAVE_HOUR,  // keep hour and the seconds into the hour
    OP_SAVE_MIN,   // keep minute and second
    OP_SAVE_WD,    // keep weekday, set up the year walk
    OP_YEAR,       // peel one year off the day count
    OP_MONTH,      // peel one month off the day count
    OP_EMIT        // hand the result to the output register
  } op_t;

  typedef enum logic [1:0] {
    DSEL_DAY,
    DSEL_HOUR,
    DSEL_MIN,
    DSEL_WEEK
  } dsel_t;

  // Jump condition: when it holds, the step counter loads the target.
  typedef enum logic [1:0] {
    COND_NEXT,       // never jump
    COND_TAKE,       // jump while a year or month was peeled off
    COND_SLOT_BUSY   // jump while the output register is still full
  } cond_t;

  typedef struct packed {
    op_t             op;
    dsel_t           dsel;
    cond_t           cond;
    logic [PcW-1:0]  target;
  } ucode_t;

  localparam logic [PcW-1:0] PC_DAY   = 4'd0;
  localparam logic [PcW-1:0] PC_YEAR  = 4'd8;
  localparam logic [PcW-1:0] PC_MONTH = 4'd9;
  localparam logic [PcW-1:0] PC_EMIT  = 4'd10;

  // The conversion program.
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{op: OP_EMIT, dsel: DSEL_DAY, cond: COND_SLOT_BUSY, target: PC_EMIT};
    unique case (pc)
      4'd0:  w = '{OP_DIV,       DSEL_DAY,  COND_NEXT, PC_DAY};
      4'd1:  w = '{OP_SAVE_DAYS, DSEL_DAY,  COND_NEXT, PC_DAY};
      4'd2:  w = '{OP_DIV,       DSEL_HOUR, COND_NEXT, PC_DAY};
      4'd3:  w = '{OP_SAVE_HOUR, DSEL_HOUR, COND_NEXT, PC_DAY};
      4'd4:  w = '{OP_DIV,       DSEL_MIN,  COND_NEXT, PC_DAY};
      4'd5:  w = '{OP_SAVE_MIN,  DSEL_MIN,  COND_NEXT, PC_DAY};
      4'd6:  w = '{OP_DIV,       DSEL_WEEK, COND_NEXT, PC_DAY};
      4'd7:  w = '{OP_SAVE_WD,   DSEL_WEEK, COND_NEXT, PC_DAY};
      4'd8:  w = '{OP_YEAR,      DSEL_DAY,  COND_TAKE, PC_YEAR};
      4'd9:  w = '{OP_MONTH,     DSEL_DAY,  COND_TAKE, PC_MONTH};
      default: w = '{OP_EMIT,    DSEL_DAY,  COND_SLOT_BUSY, PC_EMIT};
    endcase
    return w;
  endfunction

  // Days in a month, month counted from 0 = January.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    unique case (mon) inside
      4'd1:                    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/seconds_to_calendar.sv =====
// Converts a count of seconds since 2000-01-01 00:00:00 to Gregorian date, time and weekday.
// Depends on s2c_pkg for the control store, types and constants.
// Throughput: one item per conversion; the input is ready again once the result sits in
// the output register. Reset (rst_n low, synchronous) idles the sequencer and empties it.
`default_nettype none

module seconds_to_calendar
  import s2c_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Input channel.
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [SecW-1:0]  in_tdata,   // [31:0] seconds
  // Result channel.
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OutW-1:0]       out_tdata   // [11:0] year, [15:12] month, [20:16] day,
                                            // [25:21] hour, [31:26] minute,
                                            // [37:32] second, [40:38] weekday, rest zero
);

  // The converter is a small microcoded machine. A control word from ucode_rom is
  // fetched at pc_r each cycle; it picks one datapath operation and a jump condition.
  // Each of the four divisions by a constant takes two steps: a quotient step that
  // multiplies the (pre-shifted) dividend by a rounded-up reciprocal and keeps the top
  // bits, and a save step that multiplies the quotient back and subtracts to get the
  // remainder. The divisions are seconds / 86400, remainder / 3600, remainder / 60 and
  // (days + 5) / 7. Then the year walk peels 365 or 366 days per cycle, with leap years
  // tracked by mod-4, mod-100 and mod-400 counters, and the month walk peels one month per
  // cycle from the month-length table. Each walk ends on the compare that fails. The final
  // step loads the output register, which holds the result until its transfer while the
  // sequencer already accepts the next input; if the register is still full, the final
  // step waits for it.

  logic            busy_r, busy_nxt;
  logic [PcW-1:0]  pc_r, pc_nxt;
  logic [SecW-1:0] num_r, num_nxt;
  logic [RemW-1:0] rem_r, rem_nxt;
  logic [DaysW-1:0] q_r, q_nxt;
  logic [DaysW-1:0] days_r, days_nxt;
  logic [DaysW-1:0] left_r, left_nxt;
  logic [YearW-1:0] year_r, year_nxt;
  logic [1:0]      y4_r, y4_nxt;
  logic [6:0]      y100_r, y100_nxt;
  logic [8:0]      y400_r, y400_nxt;
  logic [3:0]      mon_r, mon_nxt;
  logic [4:0]      hour_r, hour_nxt;
  logic [5:0]      minute_r, minute_nxt;
  logic [5:0]      second_r, second_nxt;
  logic [2:0]      wday_r, wday_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [OutW-1:0] out_data_r, out_data_nxt;

  ucode_t          uw;
  logic [DaysW-1:0] wk_num;
  logic [50:0]     day_prod;
  logic [26:0]     hour_prod;
  logic [20:0]     min_prod;
  logic [32:0]     week_prod;
  logic [DaysW-1:0] quot;
  logic            leap;
  logic [8:0]      ylen;
  logic [4:0]      mlen;
  logic            take;
  logic            slot_free;
  logic            jump;
  logic            in_xfer;

  assign in_tready  = !busy_r;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign slot_free  = !out_valid_r || out_tready;

  assign uw = ucode_rom(pc_r);

  // Reciprocal products. The low bits dropped before each product are the power-of-two
  // part of the divisor, so every quotient is exact over its dividend's whole range.
  assign wk_num    = DaysW'(days_r + WEEK_OFFSET);
  assign day_prod  = 51'(num_r[SecW-1:7]) * 51'(RECIP_DAY);
  assign hour_prod = 27'(rem_r[16:4]) * 27'(RECIP_HOUR);
  assign min_prod  = 21'(rem_r[11:2]) * 21'(RECIP_MIN);
  assign week_prod = 33'(wk_num) * 33'(RECIP_WEEK);

  always_comb begin
    unique case (uw.dsel)
      DSEL_DAY:  quot = day_prod[50:35];
      DSEL_HOUR: quot = DaysW'(hour_prod[26:21]);
      DSEL_MIN:  quot = DaysW'(min_prod[20:14]);
      DSEL_WEEK: quot = DaysW'(week_prod[32:19]);
      default:   quot = day_prod[50:35];
    endcase
  end

  // Year and month trial subtractions.
  assign leap   = (y4_r == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
  assign ylen   = leap ? LEAP_DAYS : YEAR_DAYS;
  assign mlen   = month_len(mon_r, leap);

  always_comb begin
    take = 1'b0;
    unique case (uw.op)
      OP_YEAR:  take = left_r >= {7'd0, ylen};
      OP_MONTH: take = (mon_r < 4'd11) && (left_r >= {11'd0, mlen});
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      COND_NEXT:      jump = 1'b0;
      COND_TAKE:      jump = take;
      COND_SLOT_BUSY: jump = !slot_free;
      default:        jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    days_nxt      = days_r;
    left_nxt      = left_r;
    year_nxt      = year_r;
    y4_nxt        = y4_r;
    y100_nxt      = y100_r;
    y400_nxt      = y400_r;
    mon_nxt       = mon_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    wday_nxt      = wday_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (busy_r) begin
      pc_nxt = jump ? uw.target : PcW'(pc_r + 4'd1);
      unique case (uw.op)
        OP_DIV: begin
          q_nxt = quot;
        end
        OP_SAVE_DAYS: begin
          days_nxt = q_r;
          rem_nxt  = RemW'(num_r - SecW'(q_r) * SecW'(DIV_DAY));
        end
        OP_SAVE_HOUR: begin
          hour_nxt = q_r[4:0];
          rem_nxt  = RemW'(rem_r - RemW'(q_r) * DIV_HOUR);
        end
        OP_SAVE_MIN: begin
          minute_nxt = q_r[5:0];
          second_nxt = 6'(rem_r - RemW'(q_r) * DIV_MIN);
        end
        OP_SAVE_WD: begin
          wday_nxt = 3'(wk_num - q_r * DaysW'(DIV_WEEK) + 16'd1);
          left_nxt = days_r;
          year_nxt = BASE_YEAR;
          y4_nxt   = '0;
          y100_nxt = '0;
          y400_nxt = '0;
          mon_nxt  = '0;
        end
        OP_YEAR: begin
          if (take) begin
            left_nxt = DaysW'(left_r - {7'd0, ylen});
            year_nxt = YearW'(year_r + 12'd1);
            y4_nxt   = 2'(y4_r + 2'd1);
            y100_nxt = (y100_r == 7'd99) ? 7'd0 : 7'(y100_r + 7'd1);
            y400_nxt = (y400_r == 9'd399) ? 9'd0 : 9'(y400_r + 9'd1);
          end
        end
        OP_MONTH: begin
          if (take) begin
            left_nxt = DaysW'(left_r - {11'd0, mlen});
            mon_nxt  = 4'(mon_r + 4'd1);
          end
        end
        OP_EMIT: begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {7'd0, wday_r, second_r, minute_r, hour_r,
                             5'(left_r[4:0] + 5'd1), 4'(mon_r + 4'd1), year_r};
            busy_nxt      = 1'b0;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end else if (in_xfer) begin
      busy_nxt = 1'b1;
      pc_nxt   = PC_DAY;
      num_nxt  = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_DAY;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    days_r     <= days_nxt;
    left_r     <= left_nxt;
    year_r     <= year_nxt;
    y4_r       <= y4_nxt;
    y100_r     <= y100_nxt;
    y400_r     <= y400_nxt;
    mon_r      <= mon_nxt;
    hour_r     <= hour_nxt;
    minute_r   <= minute_nxt;
    second_r   <= second_nxt;
    wday_r     <= wday_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== design/s2c_checker.sv =====
// Port-level checks for seconds_to_calendar and the bind that attaches them.
// Depends only on the top level's ports.
`default_nettype none

module s2c_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A conversion in progress takes no further input.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again while converting");

  // A waiting result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // Every result lies inside the calendar's ranges.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[11:0] >= 12'd2000) && (out_tdata[11:0] <= 12'd2136)
      && (out_tdata[15:12] != 4'd0) && (out_tdata[15:12] <= 4'd12)
      && (out_tdata[20:16] != 5'd0) && (out_tdata[25:21] <= 5'd23)
      && (out_tdata[31:26] <= 6'd59) && (out_tdata[37:32] <= 6'd59)
      && (out_tdata[40:38] != 3'd0) && (out_tdata[47:41] == 7'd0)))
    else $error("result field out of range");

endmodule

bind seconds_to_calendar s2c_checker u_s2c_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
